@@ rtl/size_class_free_list_cache_assert.svh @@
// Assertion macros for the size class free list cache.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef SIZE_CLASS_FREE_LIST_CACHE_ASSERT_SVH
`define SIZE_CLASS_FREE_LIST_CACHE_ASSERT_SVH

`define SCFLC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define SCFLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/scflc_pkg.sv @@
// Shared types, widths and codes of the size class free list cache.
// No dependencies; used by scflc_ctrl, scflc_dp and the top level.
package scflc_pkg;

  localparam int MAX_BLOCKS_DEF = 64;
  localparam int CLASSES_DEF    = 32;

  localparam int MODE_W = 2;
  localparam int CLS_W  = 5;
  localparam int ADDR_W = 48;
  localparam int KIND_W = 2;

  localparam logic [MODE_W-1:0] MODE_POP    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REFILL = 2'd2;

  localparam logic [KIND_W-1:0] KIND_POP    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd3;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_FLUSH
  } cnt_op_t;

  typedef struct packed {
    logic              cap;
    logic              cap_dec;
    logic [KIND_W-1:0] kind;
    logic              wr;
    cnt_op_t           cnt_op;
    logic              rd;
    logic              load;
    logic              step;
  } cmd_t;

  typedef struct packed {
    logic ignore;
    logic cnt_zero;
    logic cnt_full;
    logic flushing;
    logic last_one;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/size_class_free_list_cache.sv @@
// Size class free list cache: per-class LIFO lists of free block addresses.
// Input channel in_* carries pop, free push and refill push transactions; the
//   output channel out_* carries popped, empty, flushed and rejected results.
// A push that raises no result keeps in_ready high; the next one follows at once.
// A pop of a non-empty list does one memory read of the block address RAM, then a
//   load into the result register; an empty pop or a rejected refill skips the read.
// A free push that overflows MAX_BLOCKS flushes MAX_BLOCKS/2 blocks, newest
//   first, each by a read and then a load; last marks the final flushed block.
// The address RAM has a single read port: one read per popped or flushed result.
// in_ready is high only when no transaction is in progress; a finished result
//   may still wait in the output register while the next push is taken.
// When the receiver stalls, the result register holds and the sequencer waits.
// Reset clears all per-class counts at once; the address RAM needs no clearing,
//   since only written entries are read.
// Depends on scflc_pkg, scflc_ctrl, scflc_dp and the assertion header.
`include "size_class_free_list_cache_assert.svh"

module size_class_free_list_cache import scflc_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int CLASSES    = CLASSES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [CLS_W-1:0]  in_size_class,
  input  logic [ADDR_W-1:0] in_block_addr,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] out_kind,
  output logic [CLS_W-1:0]  out_class,
  output logic [ADDR_W-1:0] out_addr,
  output logic              out_last
);

  cmd_t cmd;
  sts_t sts;

  scflc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  scflc_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .CLASSES    (CLASSES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_size_class (in_size_class),
    .in_block_addr (in_block_addr),
    .cmd           (cmd),
    .sts           (sts),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_class     (out_class),
    .out_addr      (out_addr),
    .out_last      (out_last)
  );

  `SCFLC_ASSERT_IMPL(a_idle_no_seq, in_ready, !cmd.rd && !cmd.load, "read or load while idle")
  `SCFLC_ASSERT_IMPL(a_wr_on_accept, cmd.wr, in_ready && in_valid, "write without accept")
  `SCFLC_ASSERT_NEXT(a_rd_then_busy, cmd.rd, !in_ready, "idle right after a read")
  `SCFLC_ASSERT_NEXT(a_load_valid, cmd.load, out_valid, "result load lost")

endmodule

@@ rtl/scflc_ctrl.sv @@
// Controller of the size class free list cache: decodes transactions and sequences
// reads, result loads and flushes. Depends on scflc_pkg.
module scflc_ctrl import scflc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [MODE_W-1:0] in_mode,
  output logic              in_ready,
  input  sts_t              sts,
  output cmd_t              cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.cnt_op  = CNT_HOLD;
    cmd.kind    = KIND_POP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !sts.ignore) begin
          unique case (in_mode)
            MODE_POP: begin
              cmd.cap = 1'b1;
              if (sts.cnt_zero) begin
                cmd.kind  = KIND_EMPTY;
                state_nxt = S_LOAD;
              end else begin
                cmd.kind    = KIND_POP;
                cmd.cap_dec = 1'b1;
                cmd.cnt_op  = CNT_DEC;
                state_nxt   = S_READ;
              end
            end
            MODE_FREE: begin
              cmd.wr = 1'b1;
              if (sts.cnt_full) begin
                cmd.cap    = 1'b1;
                cmd.kind   = KIND_FLUSH;
                cmd.cnt_op = CNT_FLUSH;
                state_nxt  = S_READ;
              end else begin
                cmd.cnt_op = CNT_INC;
              end
            end
            MODE_REFILL: begin
              if (sts.cnt_full) begin
                cmd.cap   = 1'b1;
                cmd.kind  = KIND_REJECT;
                state_nxt = S_LOAD;
              end else begin
                cmd.wr     = 1'b1;
                cmd.cnt_op = CNT_INC;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.load = 1'b1;
          if (sts.flushing && !sts.last_one) begin
            cmd.step  = 1'b1;
            state_nxt = S_READ;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/scflc_dp.sv @@
// Datapath of the size class free list cache: per-class counts, block address
// memory, operation registers and result register. Depends on scflc_pkg.
module scflc_dp import scflc_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int CLASSES    = CLASSES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CLS_W-1:0]  in_size_class,
  input  logic [ADDR_W-1:0] in_block_addr,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [KIND_W-1:0] out_kind,
  output logic [CLS_W-1:0]  out_class,
  output logic [ADDR_W-1:0] out_addr,
  output logic              out_last
);

  localparam int HALF      = MAX_BLOCKS / 2;
  localparam int CNT_W     = $clog2(MAX_BLOCKS + 2);
  localparam int NCLS      = (CLASSES > (1 << CLS_W)) ? (1 << CLS_W) : CLASSES;
  localparam int CIDX_W    = (NCLS > 1) ? $clog2(NCLS) : 1;
  localparam int CNT_ROWS  = 1 << CIDX_W;
  localparam int ROW       = MAX_BLOCKS + 1;
  localparam int MEM_DEPTH = NCLS * ROW;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int LIM_W     = 10;

  localparam logic [CNT_W-1:0] MAX_C       = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0] HALF_C      = CNT_W'(HALF);
  localparam logic [CNT_W-1:0] ONE_C       = CNT_W'(1);
  localparam logic [LIM_W-1:0] CLASSES_LIM = LIM_W'(CLASSES);

  function automatic logic [MEM_AW-1:0] mem_index(input logic [CLS_W-1:0] c,
                                                  input logic [CNT_W-1:0] p);
    mem_index = MEM_AW'(MEM_AW'(c) * MEM_AW'(ROW) + MEM_AW'(p));
  endfunction

  logic [CNT_W-1:0]  cnt_r [CNT_ROWS];
  logic [ADDR_W-1:0] mem [MEM_DEPTH];
  logic [ADDR_W-1:0] rdata_r;

  logic [CLS_W-1:0]  cls_r;
  logic [ADDR_W-1:0] addr_r;
  logic [KIND_W-1:0] kind_r;
  logic [CNT_W-1:0]  ptr_r;
  logic [CNT_W-1:0]  remain_r;

  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [CLS_W-1:0]  out_class_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic              out_last_r;

  logic [CIDX_W-1:0] in_cidx;
  logic [CNT_W-1:0]  cur_cnt;
  logic [ADDR_W-1:0] res_addr;

  assign in_cidx = in_size_class[CIDX_W-1:0];
  assign cur_cnt = cnt_r[in_cidx];

  assign sts.ignore   = ({{(LIM_W - CLS_W){1'b0}}, in_size_class} >= CLASSES_LIM);
  assign sts.cnt_zero = (cur_cnt == '0);
  assign sts.cnt_full = (cur_cnt >= MAX_C);
  assign sts.flushing = (kind_r == KIND_FLUSH);
  assign sts.last_one = (remain_r == ONE_C);
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CNT_ROWS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      case (cmd.cnt_op)
        CNT_INC:   cnt_r[in_cidx] <= cur_cnt + ONE_C;
        CNT_DEC:   cnt_r[in_cidx] <= cur_cnt - ONE_C;
        CNT_FLUSH: cnt_r[in_cidx] <= cur_cnt + ONE_C - HALF_C;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[mem_index(in_size_class, cur_cnt)] <= in_block_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata_r <= mem[mem_index(cls_r, ptr_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cls_r    <= in_size_class;
      addr_r   <= in_block_addr;
      kind_r   <= cmd.kind;
      ptr_r    <= cmd.cap_dec ? (cur_cnt - ONE_C) : cur_cnt;
      remain_r <= HALF_C;
    end else if (cmd.step) begin
      ptr_r    <= ptr_r - ONE_C;
      remain_r <= remain_r - ONE_C;
    end
  end

  always_comb begin
    case (kind_r) inside
      KIND_POP, KIND_FLUSH: res_addr = rdata_r;
      KIND_EMPTY:           res_addr = '0;
      default:              res_addr = addr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_kind_r  <= kind_r;
      out_class_r <= cls_r;
      out_addr_r  <= res_addr;
      out_last_r  <= (kind_r != KIND_FLUSH) || sts.last_one;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_class = out_class_r;
  assign out_addr  = out_addr_r;
  assign out_last  = out_last_r;

endmodule
